// ===== rtl/tdsa_pkg.sv =====
// Shared types and constants for the top-down ID slot allocator.
// No dependencies.
package tdsa_pkg;

   localparam int SLOT_COUNT = 65536;
   localparam int OWNER_BITS = 8;
   localparam int ID_BITS    = 16;
   localparam logic [ID_BITS-1:0] U16_MAX = 16'hFFFF;

   // Request codes
   localparam logic [1:0] REQ_RESERVE = 2'd0;
   localparam logic [1:0] REQ_ALLOC   = 2'd1;
   localparam logic [1:0] REQ_FREE    = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOSPACE  = 2'd1;
   localparam logic [1:0] ST_BADFREE  = 2'd2;
   localparam logic [1:0] ST_REPLACED = 2'd3;

   // Slot kinds
   localparam logic [1:0] KIND_FREE     = 2'd0;
   localparam logic [1:0] KIND_RESERVED = 2'd1;
   localparam logic [1:0] KIND_OWNED    = 2'd2;

   typedef struct packed {
      logic       found;
      logic [3:0] index;
   } pick_type;

endpackage

// ===== rtl/tdsa_pick16.sv =====
// Highest set bit of a 16-bit occupancy word.
// Depends on tdsa_pkg.
module tdsa_pick16 (
   input  logic [15:0]        bits,
   output tdsa_pkg::pick_type pick
);
   import tdsa_pkg::*;

   // scan upward so the highest set bit wins
   always_comb begin
      pick.found = |bits;
      pick.index = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (bits[i]) begin
            pick.index = 4'(i);
         end
      end
   end
endmodule

// ===== rtl/top_down_id_slot_allocator_top.sv =====
// Top level of the top-down ID slot allocator: slot table and four-level free bitmap.
// Depends on tdsa_pkg and tdsa_pick16.
//
// One item at a time. Reserve and free read the slot table and bitmaps in R1, then
// write back in R2; allocate picks a group from the summary register, reads the three
// bitmap levels one per cycle (A1 to A3), then writes back in A4; an allocate on a full
// table and an unused code answer in the cycle after acceptance. busy is high while an
// item is in work. The result sits on rsp_* for one cycle with rsp_valid and cannot be
// held off. After reset a clearing pass over all 65536 slots (one slot a cycle) keeps
// busy high.
module top_down_id_slot_allocator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_type,
   input  logic [tdsa_pkg::ID_BITS-1:0]       req_slot_id,
   input  logic [7:0]                         req_owner_tag,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [tdsa_pkg::ID_BITS-1:0]       rsp_granted_id
);
   import tdsa_pkg::*;

   typedef enum logic [7:0] {
      S_CLR  = 8'b00000001,
      S_IDLE = 8'b00000010,
      S_R1   = 8'b00000100,
      S_R2   = 8'b00001000,
      S_A1   = 8'b00010000,
      S_A2   = 8'b00100000,
      S_A3   = 8'b01000000,
      S_A4   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   // memories: slot entry {kind, owner}, level-0/1/2 free bitmaps; level 3 is a register
   logic [OWNER_BITS+1:0] slot_mem [SLOT_COUNT];
   logic [15:0]           l0_mem   [SLOT_COUNT/16];
   logic [15:0]           l1_mem   [SLOT_COUNT/256];
   logic [15:0]           l2_mem   [SLOT_COUNT/4096];
   logic [15:0]           l3_ff, l3_in;

   logic [OWNER_BITS+1:0] slot_rd_ff;
   logic [15:0]           l0_rd_ff, l1_rd_ff, l2_rd_ff;

   logic [ID_BITS-1:0]    clr_ff, clr_in;
   logic [1:0]            type_ff, type_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [OWNER_BITS-1:0] tag_ff, tag_in;
   logic [3:0]            grp_ff, grp_in;
   logic [3:0]            mid_ff, mid_in;
   logic [3:0]            wrd_ff, wrd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;

   pick_type pick3, pick2, pick1, pick0;

   tdsa_pick16 u_pick3 (.bits(l3_ff),    .pick(pick3));
   tdsa_pick16 u_pick2 (.bits(l2_rd_ff), .pick(pick2));
   tdsa_pick16 u_pick1 (.bits(l1_rd_ff), .pick(pick1));
   tdsa_pick16 u_pick0 (.bits(l0_rd_ff), .pick(pick0));

   // write-back controls
   logic                  wr_en;
   logic [ID_BITS-1:0]    wr_id;
   logic [OWNER_BITS+1:0] wr_slot;
   logic [15:0]           l0_new, l1_new, l2_new;
   logic [15:0]           bit0;
   logic                  accept;

   assign accept = start && (state_ff == S_IDLE);

   // next state and write-back data
   always_comb begin
      state_in      = state_ff;
      l3_in         = l3_ff;
      clr_in        = clr_ff;
      type_in       = type_ff;
      id_in         = id_ff;
      tag_in        = tag_ff;
      grp_in        = grp_ff;
      mid_in        = mid_ff;
      wrd_in        = wrd_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_id_in     = '0;
      wr_en         = 1'b0;
      wr_id         = id_ff;
      wr_slot       = slot_rd_ff;
      l0_new        = l0_rd_ff;
      l1_new        = l1_rd_ff;
      l2_new        = l2_rd_ff;
      bit0          = 16'd1 << id_ff[3:0];
      case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == U16_MAX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               type_in = req_type;
               id_in   = req_slot_id;
               tag_in  = req_owner_tag[OWNER_BITS-1:0];
               grp_in  = pick3.index;
               case (req_type)
                  REQ_RESERVE, REQ_FREE: state_in = S_R1;
                  REQ_ALLOC: begin
                     if (pick3.found) begin
                        state_in = S_A1;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOSPACE;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_R1: state_in = S_R2;
         S_R2: begin
            wr_en = 1'b1;
            if (type_ff == REQ_FREE) begin
               if (slot_rd_ff[OWNER_BITS+1:OWNER_BITS] != KIND_OWNED ||
                   slot_rd_ff[OWNER_BITS-1:0] != tag_ff) begin
                  rsp_status_in = ST_BADFREE;
               end
               wr_slot = {KIND_FREE, slot_rd_ff[OWNER_BITS-1:0]};
               l0_new  = l0_rd_ff | bit0;
            end else begin
               if (slot_rd_ff[OWNER_BITS+1:OWNER_BITS] == KIND_OWNED) begin
                  rsp_status_in = ST_REPLACED;
               end
               wr_slot = {KIND_RESERVED, slot_rd_ff[OWNER_BITS-1:0]};
               l0_new  = l0_rd_ff & ~bit0;
            end
            l1_new[id_ff[7:4]]   = |l0_new;
            l2_new[id_ff[11:8]]  = |l1_new;
            l3_in[id_ff[15:12]]  = |l2_new;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_A1: state_in = S_A2;
         S_A2: begin
            mid_in   = pick2.index;
            state_in = S_A3;
         end
         S_A3: begin
            wrd_in   = pick1.index;
            state_in = S_A4;
         end
         S_A4: begin
            wr_en   = 1'b1;
            wr_id   = {grp_ff, mid_ff, wrd_ff, pick0.index};
            wr_slot = {KIND_OWNED, tag_ff};
            l0_new  = l0_rd_ff & ~(16'd1 << pick0.index);
            l1_new[wrd_ff] = |l0_new;
            l2_new[mid_ff] = |l1_new;
            l3_in[grp_ff]  = |l2_new;
            rsp_valid_in = 1'b1;
            rsp_id_in    = wr_id;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         l3_ff        <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         l3_ff        <= l3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      id_ff         <= id_in;
      tag_ff        <= tag_in;
      grp_ff        <= grp_in;
      mid_ff        <= mid_in;
      wrd_ff        <= wrd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   // slot table: clear sweep, read on R1, write back
   always_ff @(posedge clock) begin
      if (state_ff == S_CLR) begin
         slot_mem[clr_ff] <= '0;
      end else if (wr_en) begin
         slot_mem[wr_id] <= wr_slot;
      end
      if (state_ff == S_R1) begin
         slot_rd_ff <= slot_mem[id_ff];
      end
   end

   // level-0 bitmap: one bit per slot, set when free
   always_ff @(posedge clock) begin
      if (state_ff == S_CLR) begin
         l0_mem[clr_ff[ID_BITS-5:0]] <= '1;
      end else if (wr_en) begin
         l0_mem[wr_id[ID_BITS-1:4]] <= l0_new;
      end
      if (state_ff == S_R1) begin
         l0_rd_ff <= l0_mem[id_ff[ID_BITS-1:4]];
      end else if (state_ff == S_A3) begin
         l0_rd_ff <= l0_mem[{grp_ff, mid_ff, pick1.index}];
      end
   end

   // level-1 bitmap: one bit per level-0 word holding a free slot
   always_ff @(posedge clock) begin
      if (state_ff == S_CLR) begin
         l1_mem[clr_ff[ID_BITS-9:0]] <= '1;
      end else if (wr_en) begin
         l1_mem[wr_id[ID_BITS-1:8]] <= l1_new;
      end
      if (state_ff == S_R1) begin
         l1_rd_ff <= l1_mem[id_ff[ID_BITS-1:8]];
      end else if (state_ff == S_A2) begin
         l1_rd_ff <= l1_mem[{grp_ff, pick2.index}];
      end
   end

   // level-2 bitmap: one bit per level-1 word holding a free slot
   always_ff @(posedge clock) begin
      if (state_ff == S_CLR) begin
         l2_mem[clr_ff[ID_BITS-13:0]] <= '1;
      end else if (wr_en) begin
         l2_mem[wr_id[ID_BITS-1:12]] <= l2_new;
      end
      if (state_ff == S_R1) begin
         l2_rd_ff <= l2_mem[id_ff[ID_BITS-1:12]];
      end else if (state_ff == S_A1) begin
         l2_rd_ff <= l2_mem[grp_ff];
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted_id = rsp_id_ff;

   // checks
   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted_id != '0 |-> rsp_status == ST_OK)
      else $error("granted id with non-ok status");
   a_nospace_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOSPACE |-> rsp_granted_id == '0)
      else $error("no-space result carries an id");
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the top-down ID slot allocator: directed and random requests with a
// behavioural slot table predicting status and granted slot. Depends on tdsa_pkg and the RTL.
module tb_top;
   import tdsa_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_type = 2'd0;
   logic [15:0] req_slot_id = 16'd0;
   logic [7:0]  req_owner_tag = 8'd0;
   logic        busy;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_granted_id;

   logic [1:0]  kind_tbl [SLOT_COUNT];
   logic [7:0]  owner_tbl [SLOT_COUNT];
   answer_type  answers_due [$];
   int          n_errors = 0;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b1;
   // recently granted slots, for realistic frees
   logic [15:0] granted_log [$];

   top_down_id_slot_allocator_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_slot_id(req_slot_id), .req_owner_tag(req_owner_tag),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_granted_id(rsp_granted_id)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog: clearing pass plus about 400 items
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // apply one request to the table copy and return the expected answer
   function automatic answer_type slot_answer(logic [1:0] op, logic [15:0] id,
                                              logic [7:0] tag);
      answer_type a;
      int i;
      a = '0;
      if (op == REQ_RESERVE) begin
         if (kind_tbl[id] == KIND_OWNED) a.status = ST_REPLACED;
         kind_tbl[id] = KIND_RESERVED;
      end else if (op == REQ_ALLOC) begin
         a.status = ST_NOSPACE;
         for (i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (kind_tbl[i] == KIND_FREE) begin
               kind_tbl[i] = KIND_OWNED;
               owner_tbl[i] = tag;
               a.status = ST_OK;
               a.granted = i[15:0];
               break;
            end
         end
      end else if (op == REQ_FREE) begin
         if (kind_tbl[id] != KIND_OWNED || owner_tbl[id] != tag) a.status = ST_BADFREE;
         kind_tbl[id] = KIND_FREE;
      end
      return a;
   endfunction

   // result checker
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            $display("%0t unexpected result status=%0d id=%0d", $time, rsp_status,
                     rsp_granted_id);
            n_errors++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t status expected %0d actual %0d", $time, want.status, rsp_status);
               n_errors++;
            end
            if (rsp_granted_id !== want.granted) begin
               $display("%0t granted_id expected %0d actual %0d", $time, want.granted,
                        rsp_granted_id);
               n_errors++;
            end
            if (want.status == ST_OK && want.granted != 0) granted_log.push_back(want.granted);
            if (granted_log.size() > 32) void'(granted_log.pop_front());
         end
      end
   end

   // send one item; start stays high across back-to-back items
   task automatic send_item(logic [1:0] op, logic [15:0] id, logic [7:0] tag);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= op;
      req_slot_id <= id;
      req_owner_tag <= tag;
      @(posedge clock);
      while (busy) @(posedge clock);
      answers_due.push_back(slot_answer(op, id, tag));
   endtask

   // drop start and wait for every outstanding result
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(REQ_ALLOC, 16'd0, 8'hFF);
      send_item(REQ_ALLOC, 16'hFFFF, 8'h00);
      send_item(REQ_FREE, U16_MAX, 8'hFF);      // own slot
      send_item(REQ_FREE, 16'hFFFE, 8'h01);     // foreign owner
      send_item(REQ_FREE, 16'd0, 8'h00);        // empty slot
      send_item(REQ_RESERVE, U16_MAX, 8'h00);   // free slot
      send_item(REQ_RESERVE, U16_MAX, 8'hAA);   // already reserved
      send_item(REQ_ALLOC, 16'd0, 8'h55);       // skips reserved top slot
      send_item(REQ_RESERVE, 16'hFFFE, 8'h00);  // owned: replaced
      send_item(REQ_FREE, U16_MAX, 8'h00);      // reserved slot
      send_item(REQ_RESERVE, 16'd0, 8'h00);
      send_item(REQ_FREE, 16'd0, 8'h00);
      send_item(2'd3, 16'h5A5A, 8'hA5);         // unused code
      send_item(2'd3, 16'hA5A5, 8'h5A);
      send_item(REQ_ALLOC, 16'h1234, 8'h80);
   endtask

   // table full: reserve every slot via the table copy would take too long in RTL,
   // so fill only the top region and check the search skips the reserved slots there
   task automatic test_deep_search();
      int k;
      for (k = 0; k < 20; k++) send_item(REQ_RESERVE, 16'hFFFF - k[15:0] * 16'd17,
                                         8'($urandom_range(0, 255)));
      for (k = 0; k < 6; k++) send_item(REQ_ALLOC, 16'd0, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_random(int count);
      int k;
      logic [1:0] op;
      logic [15:0] id;
      int sel;
      for (k = 0; k < count; k++) begin
         op = 2'($urandom_range(0, 3));
         sel = $urandom_range(0, 3);
         if (sel < 2 && granted_log.size() > 0)
            id = granted_log[$urandom_range(0, granted_log.size() - 1)];
         else if (sel == 2)
            id = 16'hFFFF - 16'($urandom_range(0, 63));
         else
            id = 16'($urandom_range(0, 65535));
         send_item(op, id, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_pause();
      wait_drained();
      send_item(REQ_ALLOC, 16'd0, 8'h11);
   endtask

   initial begin
      int k;
      for (k = 0; k < SLOT_COUNT; k++) begin
         kind_tbl[k] = KIND_FREE;
         owner_tbl[k] = 8'd0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
      test_directed();
      test_deep_search();
      test_random(200);
      test_pause();
      idle_on = 1'b0;
      test_random(150);
      wait_drained();
      repeat (20) @(posedge clock);
      if (n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
